[rtl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Item layouts for the request, response and front-to-back queue.
// ----------------------------------------------------------------------------
`default_nettype none
package mi3_pkg;

   localparam int ELEM_W = 32;
   localparam int N_ELEM = 9;
   localparam int PROD_W = 64;
   localparam int ADJ_W  = 65;
   localparam int ADJM_W = 64;
   localparam int DET_W  = 97;
   localparam int DETM_W = 96;
   localparam int QUO_W  = 32;
   localparam int REM_W  = 130;

   // cofactor operand indexes: adj = e[a]*e[b] - e[c]*e[d]
   localparam int unsigned ADJ_IDX [0:8][0:3] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic signed [ELEM_W-1:0] m00;
      logic signed [ELEM_W-1:0] m01;
      logic signed [ELEM_W-1:0] m02;
      logic signed [ELEM_W-1:0] m10;
      logic signed [ELEM_W-1:0] m11;
      logic signed [ELEM_W-1:0] m12;
      logic signed [ELEM_W-1:0] m20;
      logic signed [ELEM_W-1:0] m21;
      logic signed [ELEM_W-1:0] m22;
   } mi3_req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] inv00;
      logic signed [ELEM_W-1:0] inv01;
      logic signed [ELEM_W-1:0] inv02;
      logic signed [ELEM_W-1:0] inv10;
      logic signed [ELEM_W-1:0] inv11;
      logic signed [ELEM_W-1:0] inv12;
      logic signed [ELEM_W-1:0] inv20;
      logic signed [ELEM_W-1:0] inv21;
      logic signed [ELEM_W-1:0] inv22;
      logic signed [ELEM_W-1:0] determinant;
      logic                     singular;
      logic                     saturated;
   } mi3_rsp_type;

   typedef struct packed {
      logic                           singular;
      logic                           det_neg;
      logic [DETM_W-1:0]              det_mag;
      logic [N_ELEM-1:0]              adj_neg;
      logic [N_ELEM-1:0][ADJM_W-1:0]  adj_mag;
   } mi3_item_type;

endpackage
`default_nettype wire

[rtl/mi3_front.sv]
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Six stages: products, adjugate, magnitudes, partial products, terms, sum.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mi3_pkg::mi3_req_type req_data,
   output logic                 item_valid,
   output mi3_pkg::mi3_item_type item,
   input  logic                 item_full
);
   import mi3_pkg::*;

   logic                      f_en;
   logic signed [ELEM_W-1:0]  e [N_ELEM];
   logic [5:0]                vld_ff, vld_in;

   logic signed [PROD_W-1:0]  pp_ff [N_ELEM], pp_in [N_ELEM];
   logic signed [PROD_W-1:0]  pq_ff [N_ELEM], pq_in [N_ELEM];
   logic signed [ELEM_W-1:0]  row1_ff [3], row1_in [3];
   logic signed [ELEM_W-1:0]  row2_ff [3], row2_in [3];
   logic signed [ADJ_W-1:0]   adj_ff [N_ELEM], adj_in [N_ELEM];
   logic [ADJM_W-1:0]         mag3_ff [N_ELEM], mag3_in [N_ELEM];
   logic                      neg3_ff [N_ELEM], neg3_in [N_ELEM];
   logic [ELEM_W-1:0]         em_ff [3], em_in [3];
   logic                      eneg_ff [3], eneg_in [3];
   logic [PROD_W-1:0]         plo_ff [3], plo_in [3];
   logic [PROD_W-1:0]         phi_ff [3], phi_in [3];
   logic                      tneg_ff [3], tneg_in [3];
   logic [ADJM_W-1:0]         mag4_ff [N_ELEM], mag5_ff [N_ELEM], mag6_ff [N_ELEM];
   logic                      neg4_ff [N_ELEM], neg5_ff [N_ELEM], neg6_ff [N_ELEM];
   logic signed [DET_W-1:0]   term_ff [3], term_in [3];
   logic signed [DET_W-1:0]   det_ff, det_in;

   assign e[0] = req_data.m00;
   assign e[1] = req_data.m01;
   assign e[2] = req_data.m02;
   assign e[3] = req_data.m10;
   assign e[4] = req_data.m11;
   assign e[5] = req_data.m12;
   assign e[6] = req_data.m20;
   assign e[7] = req_data.m21;
   assign e[8] = req_data.m22;

   assign f_en      = !(vld_ff[5] && item_full);
   assign req_stall = !f_en;
   assign vld_in    = {vld_ff[4:0], req_valid};

   always_comb begin
      logic [DETM_W-1:0] t;
      t = '0;
      for (int i = 0; i < N_ELEM; i++) begin
         pp_in[i]   = e[ADJ_IDX[i][0]] * e[ADJ_IDX[i][1]];
         pq_in[i]   = e[ADJ_IDX[i][2]] * e[ADJ_IDX[i][3]];
         adj_in[i]  = ADJ_W'(pp_ff[i]) - ADJ_W'(pq_ff[i]);
         neg3_in[i] = adj_ff[i][ADJ_W-1];
         mag3_in[i] = adj_ff[i][ADJ_W-1] ? ADJM_W'(-adj_ff[i]) : adj_ff[i][ADJM_W-1:0];
      end
      for (int j = 0; j < 3; j++) begin
         row1_in[j] = e[j];
         row2_in[j] = row1_ff[j];
         eneg_in[j] = row2_ff[j][ELEM_W-1];
         em_in[j]   = row2_ff[j][ELEM_W-1] ? ELEM_W'(-row2_ff[j]) : row2_ff[j];
         plo_in[j]  = PROD_W'(mag3_ff[3*j][31:0]) * PROD_W'(em_ff[j]);
         phi_in[j]  = PROD_W'(mag3_ff[3*j][63:32]) * PROD_W'(em_ff[j]);
         tneg_in[j] = neg3_ff[3*j] ^ eneg_ff[j];
         t          = DETM_W'(plo_ff[j]) + {phi_ff[j], 32'b0};
         term_in[j] = tneg_ff[j] ? (~{1'b0, t} + 1'b1) : {1'b0, t};
      end
      det_in = term_ff[0] + term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (f_en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) begin
         pp_ff   <= pp_in;
         pq_ff   <= pq_in;
         row1_ff <= row1_in;
         row2_ff <= row2_in;
         adj_ff  <= adj_in;
         mag3_ff <= mag3_in;
         neg3_ff <= neg3_in;
         em_ff   <= em_in;
         eneg_ff <= eneg_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         tneg_ff <= tneg_in;
         mag4_ff <= mag3_ff;
         neg4_ff <= neg3_ff;
         term_ff <= term_in;
         mag5_ff <= mag4_ff;
         neg5_ff <= neg4_ff;
         det_ff  <= det_in;
         mag6_ff <= mag5_ff;
         neg6_ff <= neg5_ff;
      end
   end

   always_comb begin
      item_valid    = vld_ff[5];
      item.singular = (det_ff == '0);
      item.det_neg  = det_ff[DET_W-1];
      item.det_mag  = det_ff[DET_W-1] ? DETM_W'(-det_ff) : det_ff[DETM_W-1:0];
      for (int i = 0; i < N_ELEM; i++) begin
         item.adj_neg[i] = neg6_ff[i];
         item.adj_mag[i] = mag6_ff[i];
      end
   end

endmodule
`default_nettype wire

[rtl/mi3_queue.sv]
// ----------------------------------------------------------------------------
// mi3_queue: two-entry item queue between front and back
// Push when valid and not full; the user must pop only while not empty, which the queue does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mi3_pkg::mi3_item_type in_item,
   output logic                  full,
   output logic                  not_empty,
   input  logic                  pop,
   output mi3_pkg::mi3_item_type out_item
);
   import mi3_pkg::*;

   mi3_item_type ent_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign push      = in_valid && !full;
   assign out_item  = ent_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

[rtl/mi3_back.sv]
// ----------------------------------------------------------------------------
// mi3_back: pipelined division and saturation
// Setup stage, one restoring quotient bit per stage for nine lanes, output reg.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  mi3_pkg::mi3_item_type item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mi3_pkg::mi3_rsp_type  rsp_data
);
   import mi3_pkg::*;

   localparam int NS = QUO_W + 1;

   typedef struct packed {
      logic              singular;
      logic              det_neg;
      logic [DETM_W-1:0] det_mag;
      logic [N_ELEM-1:0] adj_neg;
   } mi3_meta_type;

   logic              b_en;
   logic [NS-1:0]     vld_ff, vld_in;
   mi3_meta_type      meta_ff [NS], meta_in [NS];
   logic [REM_W-1:0]  rem_ff [NS][N_ELEM], rem_in [NS][N_ELEM];
   logic [QUO_W-1:0]  quo_ff [NS][N_ELEM], quo_in [NS][N_ELEM];
   logic              ovf_ff [NS][N_ELEM], ovf_in [NS][N_ELEM];
   logic              rsp_valid_ff, rsp_valid_in;
   mi3_rsp_type       rsp_ff, rsp_in;

   function automatic logic [ELEM_W:0] sat32(input logic neg, input logic big,
                                             input logic [DETM_W-1:0] mag);
      logic [DETM_W-1:0] lim;
      logic [DETM_W-1:0] m;
      logic              s;
      lim = neg ? DETM_W'(33'h080000000) : DETM_W'(33'h07FFFFFFF);
      s   = big || (mag > lim);
      m   = s ? lim : mag;
      return {s, neg ? ELEM_W'(-m[ELEM_W-1:0]) : m[ELEM_W-1:0]};
   endfunction

   assign b_en      = !(rsp_valid_ff && rsp_stall);
   assign item_pop  = b_en && item_valid;
   assign vld_in    = {vld_ff[NS-2:0], item_pop};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [REM_W-1:0] num;
      logic [REM_W-1:0] dsh;
      meta_in[0].singular = item.singular;
      meta_in[0].det_neg  = item.det_neg;
      meta_in[0].det_mag  = item.det_mag;
      meta_in[0].adj_neg  = item.adj_neg;
      dsh = REM_W'(item.det_mag) << QUO_W;
      for (int l = 0; l < N_ELEM; l++) begin
         num          = REM_W'(item.adj_mag[l]) << (2 * FRAC_BITS);
         rem_in[0][l] = num;
         quo_in[0][l] = '0;
         ovf_in[0][l] = (num >= dsh);
      end
      for (int k = 1; k < NS; k++) begin
         meta_in[k] = meta_ff[k-1];
         dsh = REM_W'(meta_ff[k-1].det_mag) << (QUO_W - k);
         for (int l = 0; l < N_ELEM; l++) begin
            ovf_in[k][l] = ovf_ff[k-1][l];
            quo_in[k][l] = quo_ff[k-1][l];
            rem_in[k][l] = rem_ff[k-1][l];
            if (rem_ff[k-1][l] >= dsh) begin
               rem_in[k][l] = rem_ff[k-1][l] - dsh;
               quo_in[k][l][QUO_W-k] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [ELEM_W:0]     r [N_ELEM];
      logic [ELEM_W:0]     dr;
      logic [DETM_W-1:0]   dm;
      logic                neg;
      mi3_meta_type        mt;
      mt = meta_ff[NS-1];
      for (int l = 0; l < N_ELEM; l++) begin
         neg = (mt.adj_neg[l] ^ mt.det_neg) &&
               (ovf_ff[NS-1][l] || (quo_ff[NS-1][l] != '0));
         r[l] = sat32(neg, ovf_ff[NS-1][l], DETM_W'(quo_ff[NS-1][l]));
      end
      dm = mt.det_mag >> (2 * FRAC_BITS);
      dr = sat32(mt.det_neg && (dm != '0), 1'b0, dm);
      rsp_in.inv00       = r[0][ELEM_W-1:0];
      rsp_in.inv01       = r[1][ELEM_W-1:0];
      rsp_in.inv02       = r[2][ELEM_W-1:0];
      rsp_in.inv10       = r[3][ELEM_W-1:0];
      rsp_in.inv11       = r[4][ELEM_W-1:0];
      rsp_in.inv12       = r[5][ELEM_W-1:0];
      rsp_in.inv20       = r[6][ELEM_W-1:0];
      rsp_in.inv21       = r[7][ELEM_W-1:0];
      rsp_in.inv22       = r[8][ELEM_W-1:0];
      rsp_in.determinant = dr[ELEM_W-1:0];
      rsp_in.singular    = 1'b0;
      rsp_in.saturated   = dr[ELEM_W] | r[0][ELEM_W] | r[1][ELEM_W] | r[2][ELEM_W] |
                           r[3][ELEM_W] | r[4][ELEM_W] | r[5][ELEM_W] |
                           r[6][ELEM_W] | r[7][ELEM_W] | r[8][ELEM_W];
      if (mt.singular) begin
         rsp_in          = '0;
         rsp_in.singular = 1'b1;
      end
      rsp_valid_in = vld_ff[NS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (b_en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         meta_ff <= meta_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         ovf_ff  <= ovf_in;
         rsp_ff  <= rsp_in;
      end
   end

endmodule
`default_nettype wire

[rtl/matrix_inverse_3x3.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 fixed-point matrix inverse by adjugate
// Cofactors and determinant in a front pipeline, queued, then divided.
// ----------------------------------------------------------------------------
//  channel   ports                          direction
//  req       req_valid req_stall req_data   in  (nine elements)
//  rsp       rsp_valid rsp_stall rsp_data   out (inverse, det, flags)
//
// One item per cycle sustained while rsp_stall is low. The path runs through six
// front stages, one queue slot, a setup stage, 32 quotient-bit stages and the
// output register. The 32-stage restoring divider sets the latency.
// Reset clears stage valids and the queue. A stalled response holds the
// back pipeline; the two-entry queue then fills before req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix_inverse_3x3 #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mi3_pkg::mi3_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mi3_pkg::mi3_rsp_type rsp_data
);
   import mi3_pkg::*;

   mi3_item_type f_item, q_item;
   logic         f_valid, q_full, q_not_empty, q_pop;

   mi3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (f_valid),
      .item       (f_item),
      .item_full  (q_full)
   );

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .out_item  (q_item)
   );

   mi3_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (q_item),
      .item_pop   (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

[test/matrix_inverse_3x3_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_checker: response checker for the 3x3 matrix inverse
// Watches both channels. Each accepted matrix item is turned into an
// expected inverse and determinant. Each accepted response is compared
// field by field, in order, with the oldest expected item.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  mi3_pkg::mi3_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mi3_pkg::mi3_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending
);
   import mi3_pkg::*;

   mi3_rsp_type inverse_queue[$];
   int          fails = 0;

   assign fail_count = fails;
   assign pending    = inverse_queue.size();

   function automatic logic [32:0] clamp32(input logic neg, input logic [129:0] mag);
      logic [129:0] lim;
      logic         clipped;
      lim     = neg ? 130'h8000_0000 : 130'h7FFF_FFFF;
      clipped = mag > lim;
      if (clipped) mag = lim;
      return {clipped, neg ? -mag[31:0] : mag[31:0]};
   endfunction

   function automatic mi3_rsp_type inverse_of(input mi3_req_type m);
      logic        [8:0][31:0] flat;
      logic signed [129:0]     e[9];
      logic signed [129:0]     cof[9];
      logic signed [129:0]     det;
      logic        [129:0]     dmag, amag, quo;
      logic        [9:0][31:0] vals;
      logic        [32:0]      c;
      logic                    dneg, neg, sat;
      mi3_rsp_type             r;
      flat = m;
      for (int i = 0; i < 9; i++) e[i] = $signed(flat[8-i]);
      for (int i = 0; i < 9; i++)
         cof[i] = e[ADJ_IDX[i][0]] * e[ADJ_IDX[i][1]] - e[ADJ_IDX[i][2]] * e[ADJ_IDX[i][3]];
      det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      sat  = 1'b0;
      dneg = det < 0;
      dmag = dneg ? -det : det;
      for (int i = 0; i < 9; i++) begin
         amag = (cof[i] < 0) ? -cof[i] : cof[i];
         quo  = (amag << 32) / dmag;
         neg  = (cof[i] < 0) != dneg;
         if (quo == 0) neg = 1'b0;
         c = clamp32(neg, quo);
         sat = sat | c[32];
         vals[9-i] = c[31:0];
      end
      quo = dmag >> 32;
      c = clamp32(dneg && quo != 0, quo);
      sat = sat | c[32];
      vals[0] = c[31:0];
      r = {vals, 1'b0, sat};
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      logic [9:0][31:0] got_v, want_v;
      mi3_rsp_type      want;
      string            names[10];
      names = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12",
                "inv20", "inv21", "inv22", "determinant"};
      if (!reset) begin
         if (req_valid && !req_stall) inverse_queue.push_back(inverse_of(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (inverse_queue.size() == 0) begin
               report("unexpected item", rsp_data[33:2], '0);
            end else begin
               want   = inverse_queue.pop_front();
               got_v  = rsp_data[321:2];
               want_v = want[321:2];
               for (int i = 0; i < 10; i++)
                  if (got_v[9-i] !== want_v[9-i]) report(names[i], got_v[9-i], want_v[9-i]);
               if (rsp_data.singular !== want.singular)
                  report("singular", rsp_data.singular, want.singular);
               if (rsp_data.saturated !== want.saturated)
                  report("saturated", rsp_data.saturated, want.saturated);
            end
         end
      end
   end

   final begin
   end
endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the 3x3 matrix inverse
// Drives directed matrices (identity, zero, extremes, singular, tiny
// determinant) then random matrices with random idling on both channels,
// including one long response hold-off. Checking is done by the checker.
// ----------------------------------------------------------------------------
module testbench;
   import mi3_pkg::*;

   localparam logic [31:0] ONE = 32'h0001_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mi3_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mi3_rsp_type rsp_data;
   int          fail_count, pending;
   bit          hold_request = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   bit          steady = 1'b0;

   always #5 clock = ~clock;

   matrix_inverse_3x3 u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   matrix_inverse_3x3_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic mi3_req_type matrix(input logic [31:0] a0, a1, a2, a3, a4,
                                          a5, a6, a7, a8);
      return {a0, a1, a2, a3, a4, a5, a6, a7, a8};
   endfunction

   function automatic logic [31:0] elem(input int kind);
      case (kind)
         0: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         1: return $urandom;
         2: return $urandom_range(0, 31) - 16;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return ONE;
               3: return '0;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   function automatic mi3_req_type random_matrix();
      logic [8:0][31:0] f;
      int r, kind;
      r = $urandom_range(0, 99);
      kind = r < 60 ? 0 : r < 75 ? 1 : r < 85 ? 2 : 3;
      for (int i = 0; i < 9; i++) f[i] = elem(kind);
      if (r >= 90 && r < 95) f[2:0] = f[8:6];
      if (r >= 95) begin
         f[8] = '0; f[5] = '0; f[2] = '0;
      end
      return f;
   endfunction

   task automatic send(input mi3_req_type m);
      int n;
      req_data  <= m;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      n = idle_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
         hold_left <= idle_len();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send(matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
      send(matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send(matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send(matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
      send(matrix(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF));
      send(matrix(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000));
      send(matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF));
      send(matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF));
      send(matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                  7 * ONE, 8 * ONE, 9 * ONE));
      send(matrix(2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, 32'h0000_8000));
      send(matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
      send(matrix(0, 0, ONE, 0, ONE, 0, ONE, 0, 0));
      send(matrix(ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE));
      send(matrix(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000));
      send(matrix(2, 0, 0, 0, 3, 0, 0, 0, -5));
      send(matrix(ONE, 2 * ONE, 0, 2 * ONE, 4 * ONE, 0, 0, 0, ONE));
      send(matrix(3 * ONE, -ONE, 2 * ONE, -ONE, 4 * ONE, ONE, 2 * ONE, ONE, 5 * ONE));
      send(matrix(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                  0, 0, 1));

      for (int k = 0; k < 900; k++) begin
         steady = (k >= 450 && k < 550);
         if (k == 300) hold_request = 1'b1;
         send(random_matrix());
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
